### hw/rtl/hevc_aub_pkg.sv
`timescale 1ns / 1ps

package hevc_aub_pkg;

    // stream offset width; offsets wrap at this many bits
    localparam int OFFSET_BITS = 32;

    // five held bytes plus the arriving one form the start code window
    localparam int WIN_DEPTH = 5;
    localparam int FILL_W    = 3;

    // start code skip count loaded after every match
    localparam logic [1:0] SKIP_LOAD = 2'd2;

    // nal unit type ranges and header bits
    localparam logic [7:0] NAL_TYPE_MASK   = 8'h7E;
    localparam int         FIRST_SLICE_BIT = 7;
    localparam logic [5:0] LAST_SLICE_TYPE = 6'd21;
    localparam logic [5:0] FIRST_PS_TYPE   = 6'd32;
    localparam logic [5:0] LAST_PS_TYPE    = 6'd34;

    // record kinds
    localparam logic KIND_BOUNDARY = 1'b0;
    localparam logic KIND_END      = 1'b1;

    // queue between classifier and output side
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // one classified request: an optional boundary and an optional end record
    typedef struct packed {
        logic                   bnd_valid;
        logic                   bnd_ps;
        logic [OFFSET_BITS-1:0] bnd_offset;
        logic                   end_valid;
        logic [OFFSET_BITS-1:0] end_offset;
    } entry_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

### hw/rtl/hevc_aub_if.sv
`timescale 1ns / 1ps

// byte input channel
interface hevc_aub_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// result channel
interface hevc_aub_out_if;
    logic                                valid;
    logic                                ready;
    logic [hevc_aub_pkg::OFFSET_BITS-1:0] offset;
    logic                                record_kind;
    logic                                starts_with_param_set;
    logic                                last_of_run;

    modport source (output valid, output offset, output record_kind,
                    output starts_with_param_set, output last_of_run, input ready);
    modport sink (input valid, input offset, input record_kind,
                  input starts_with_param_set, input last_of_run, output ready);
endinterface

### hw/rtl/hevc_aub_finder_unit.sv
`timescale 1ns / 1ps

// Finds access-unit boundaries in an HEVC Annex B byte stream taken one byte
// per request. A boundary is reported at the offset of its 00 00 01 start
// code when a first slice segment follows outside a parameter-set run, or
// when a VPS/SPS/PPS opens such a run (starts_with_param_set = 1). A byte
// flagged end_of_stream yields an end record carrying the stream length,
// after any boundary from the final window, and restarts offsets at zero;
// the parameter-set flag carries into the next stream. Offsets wrap at 2^32.
// The block takes one byte every cycle while its request queue is not full.
// Results are registered on the way out; a byte that causes both a boundary
// and an end record needs two transfers on the output side, and a four-entry
// request queue between the classifier and the output register absorbs that.
module hevc_access_unit_boundary_finder_unit (
    input  logic            clk,
    input  logic            rst_n,
    hevc_aub_in_if.sink     in_ch,
    hevc_aub_out_if.source  out_ch
);

    logic                        push;
    logic                        pop;
    hevc_aub_pkg::entry_t        push_data;
    hevc_aub_pkg::entry_t        head;
    hevc_aub_pkg::queue_stat_t   stat;

    hevc_aub_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .stat      (stat),
        .push      (push),
        .push_data (push_data)
    );

    hevc_aub_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    hevc_aub_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .stat   (stat),
        .pop    (pop),
        .out_ch (out_ch)
    );

    // queue never written when full
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !stat.full)
        else $error("request queue overflow");

    // queue never read when empty
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !stat.empty)
        else $error("request queue underflow");

    // an end record always closes its run and carries no parameter-set mark
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.record_kind == hevc_aub_pkg::KIND_END)) |->
        (out_ch.last_of_run && !out_ch.starts_with_param_set))
        else $error("malformed end record");

    // a boundary that is not last must be followed by its end record
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.last_of_run) |=>
        (out_ch.valid && (out_ch.record_kind == hevc_aub_pkg::KIND_END)))
        else $error("missing end record after boundary");

endmodule

### hw/rtl/hevc_aub_front.sv
`timescale 1ns / 1ps

module hevc_aub_front (
    input  logic                        clk,
    input  logic                        rst_n,
    hevc_aub_in_if.sink                 in_ch,
    input  hevc_aub_pkg::queue_stat_t   stat,
    output logic                        push,
    output hevc_aub_pkg::entry_t        push_data
);

    logic [7:0]                               win_reg [hevc_aub_pkg::WIN_DEPTH];
    logic [7:0]                               win_next [hevc_aub_pkg::WIN_DEPTH];
    logic [hevc_aub_pkg::FILL_W-1:0]          fill_reg, fill_next;
    logic [hevc_aub_pkg::OFFSET_BITS-1:0]     offset_reg, offset_next;
    logic [1:0]                               skip_reg, skip_next;
    logic                                     in_ps_reg, in_ps_next;

    logic                                     accept;
    logic                                     win_full;
    logic                                     start_code;
    logic [5:0]                               unit_type;
    logic                                     is_slice;
    logic                                     is_ps;
    logic                                     examine;
    logic [hevc_aub_pkg::OFFSET_BITS-1:0]     offset_inc;

    assign in_ch.ready = !stat.full;
    assign accept      = in_ch.valid && in_ch.ready;

    // window compare against the held bytes and the arriving byte
    assign win_full   = (fill_reg == hevc_aub_pkg::FILL_W'(hevc_aub_pkg::WIN_DEPTH));
    assign start_code = (win_reg[0] == 8'h00) && (win_reg[1] == 8'h00) &&
                        (win_reg[2] == 8'h01);
    assign unit_type  = win_reg[3][6:1] & hevc_aub_pkg::NAL_TYPE_MASK[6:1];
    assign is_slice   = (unit_type <= hevc_aub_pkg::LAST_SLICE_TYPE) &&
                        in_ch.data_byte[hevc_aub_pkg::FIRST_SLICE_BIT];
    assign is_ps      = (unit_type >= hevc_aub_pkg::FIRST_PS_TYPE) &&
                        (unit_type <= hevc_aub_pkg::LAST_PS_TYPE);
    assign examine    = win_full && (skip_reg == 2'd0) && start_code;
    assign offset_inc = offset_reg + hevc_aub_pkg::OFFSET_BITS'(1);

    // classification and next state
    always_comb
    begin
        push_data.bnd_valid  = 1'b0;
        push_data.bnd_ps     = 1'b0;
        push_data.bnd_offset = offset_reg -
                               hevc_aub_pkg::OFFSET_BITS'(hevc_aub_pkg::WIN_DEPTH);
        push_data.end_valid  = in_ch.end_of_stream;
        push_data.end_offset = offset_inc;
        skip_next  = skip_reg;
        in_ps_next = in_ps_reg;

        if (win_full && (skip_reg != 2'd0))
        begin
            skip_next = skip_reg - 2'd1;
        end
        else if (examine)
        begin
            skip_next = hevc_aub_pkg::SKIP_LOAD;
            if (is_slice)
            begin
                push_data.bnd_valid = !in_ps_reg;
                in_ps_next          = 1'b0;
            end
            else if (is_ps)
            begin
                push_data.bnd_valid = !in_ps_reg;
                push_data.bnd_ps    = 1'b1;
                in_ps_next          = 1'b1;
            end
        end

        for (int i = 0; i < hevc_aub_pkg::WIN_DEPTH - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[hevc_aub_pkg::WIN_DEPTH - 1] = in_ch.data_byte;
        fill_next   = win_full ? fill_reg : fill_reg + hevc_aub_pkg::FILL_W'(1);
        offset_next = offset_inc;

        // end of stream clears everything but the parameter set flag
        if (in_ch.end_of_stream)
        begin
            for (int i = 0; i < hevc_aub_pkg::WIN_DEPTH; i++)
            begin
                win_next[i] = 8'h00;
            end
            fill_next   = '0;
            offset_next = '0;
            skip_next   = 2'd0;
        end
    end

    assign push = accept && (push_data.bnd_valid || push_data.end_valid);

    // stream state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hevc_aub_pkg::WIN_DEPTH; i++)
            begin
                win_reg[i] <= 8'h00;
            end
            fill_reg   <= '0;
            offset_reg <= '0;
            skip_reg   <= 2'd0;
            in_ps_reg  <= 1'b0;
        end
        else if (accept)
        begin
            win_reg    <= win_next;
            fill_reg   <= fill_next;
            offset_reg <= offset_next;
            skip_reg   <= skip_next;
            in_ps_reg  <= in_ps_next;
        end
    end

endmodule

### hw/rtl/hevc_aub_queue.sv
`timescale 1ns / 1ps

module hevc_aub_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  hevc_aub_pkg::entry_t        push_data,
    input  logic                        pop,
    output hevc_aub_pkg::entry_t        head,
    output hevc_aub_pkg::queue_stat_t   stat
);

    hevc_aub_pkg::entry_t                 slot_reg [hevc_aub_pkg::QUEUE_DEPTH];
    logic [hevc_aub_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [hevc_aub_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [hevc_aub_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == hevc_aub_pkg::QCNT_W'(hevc_aub_pkg::QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head       = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + hevc_aub_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + hevc_aub_pkg::QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + hevc_aub_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - hevc_aub_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/hevc_aub_back.sv
`timescale 1ns / 1ps

module hevc_aub_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hevc_aub_pkg::entry_t        head,
    input  hevc_aub_pkg::queue_stat_t   stat,
    output logic                        pop,
    hevc_aub_out_if.source              out_ch
);

    typedef enum logic [1:0] {
        PH_FIRST  = 2'b01,
        PH_SECOND = 2'b10
    } phase_t;

    phase_t                                   phase_reg, phase_next;
    logic                                     out_valid_reg, out_valid_next;
    logic [hevc_aub_pkg::OFFSET_BITS-1:0]     offset_reg, offset_next;
    logic                                     kind_reg, kind_next;
    logic                                     ps_reg, ps_next;
    logic                                     last_reg, last_next;
    logic                                     load;

    assign load = !stat.empty && (!out_valid_reg || out_ch.ready);

    // pick the next result out of the head request
    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        offset_next    = offset_reg;
        kind_next      = kind_reg;
        ps_next        = ps_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        if (load)
        begin
            out_valid_next = 1'b1;
            unique case (phase_reg)
                PH_FIRST:
                begin
                    if (head.bnd_valid)
                    begin
                        offset_next = head.bnd_offset;
                        kind_next   = hevc_aub_pkg::KIND_BOUNDARY;
                        ps_next     = head.bnd_ps;
                        last_next   = !head.end_valid;
                        pop         = !head.end_valid;
                        phase_next  = head.end_valid ? PH_SECOND : PH_FIRST;
                    end
                    else
                    begin
                        offset_next = head.end_offset;
                        kind_next   = hevc_aub_pkg::KIND_END;
                        ps_next     = 1'b0;
                        last_next   = 1'b1;
                        pop         = 1'b1;
                    end
                end
                PH_SECOND:
                begin
                    offset_next = head.end_offset;
                    kind_next   = hevc_aub_pkg::KIND_END;
                    ps_next     = 1'b0;
                    last_next   = 1'b1;
                    pop         = 1'b1;
                    phase_next  = PH_FIRST;
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        kind_reg   <= kind_next;
        ps_reg     <= ps_next;
        last_reg   <= last_next;
    end

    assign out_ch.valid                 = out_valid_reg;
    assign out_ch.offset                = offset_reg;
    assign out_ch.record_kind           = kind_reg;
    assign out_ch.starts_with_param_set = ps_reg;
    assign out_ch.last_of_run           = last_reg;

endmodule

### tb/hevc_aub_boundary_monitor.sv
`timescale 1ns / 1ps

// watches both channels, predicts the boundary and end records of every
// accepted byte and compares them in order with what the block emits
module hevc_aub_boundary_monitor (
    input  logic    clk,
    input  logic    rst_n,
    hevc_aub_in_if  in_mon,
    hevc_aub_out_if out_mon,
    output int      mismatches,
    output int      records_pending
);

    typedef struct packed {
        logic [hevc_aub_pkg::OFFSET_BITS-1:0] offset;
        logic                                 kind;
        logic                                 param_set;
        logic                                 last;
    } aub_record_t;

    aub_record_t expected_records[$];

    // predicted state of the finder
    logic [7:0]                           held_bytes [hevc_aub_pkg::WIN_DEPTH];
    logic [hevc_aub_pkg::OFFSET_BITS-1:0] stream_pos;
    logic                                 in_ps_run;
    logic [1:0]                           skip_count;
    logic [hevc_aub_pkg::FILL_W-1:0]      held_count;

    initial
    begin
        held_bytes      = '{default: 8'h00};
        stream_pos      = '0;
        in_ps_run       = 1'b0;
        skip_count      = '0;
        held_count      = '0;
        mismatches      = 0;
        records_pending = 0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic queue_record(input logic [hevc_aub_pkg::OFFSET_BITS-1:0] offset,
                                input logic kind, input logic param_set);
        aub_record_t rec;
        rec.offset    = offset;
        rec.kind      = kind;
        rec.param_set = param_set;
        rec.last      = 1'b0;
        expected_records.push_back(rec);
    endtask

    // window compare on the five held bytes plus the arriving one
    task automatic find_boundaries(input logic [7:0] value, input logic final_byte);
        int                                   size_before;
        logic [5:0]                           unit_type;
        logic [hevc_aub_pkg::OFFSET_BITS-1:0] code_pos;
        size_before = expected_records.size();
        if (held_count >= hevc_aub_pkg::WIN_DEPTH)
        begin
            if (skip_count != 0)
                skip_count--;
            else if (held_bytes[0] == 8'h00 && held_bytes[1] == 8'h00 &&
                     held_bytes[2] == 8'h01)
            begin
                unit_type = 6'((held_bytes[3] & hevc_aub_pkg::NAL_TYPE_MASK) >> 1);
                code_pos  = stream_pos -
                            hevc_aub_pkg::OFFSET_BITS'(hevc_aub_pkg::WIN_DEPTH);
                if (unit_type <= hevc_aub_pkg::LAST_SLICE_TYPE &&
                    value[hevc_aub_pkg::FIRST_SLICE_BIT])
                begin
                    if (!in_ps_run)
                        queue_record(code_pos, hevc_aub_pkg::KIND_BOUNDARY, 1'b0);
                    else
                        in_ps_run = 1'b0;
                end
                else if (unit_type >= hevc_aub_pkg::FIRST_PS_TYPE &&
                         unit_type <= hevc_aub_pkg::LAST_PS_TYPE)
                begin
                    if (!in_ps_run)
                        queue_record(code_pos, hevc_aub_pkg::KIND_BOUNDARY, 1'b1);
                    in_ps_run = 1'b1;
                end
                skip_count = hevc_aub_pkg::SKIP_LOAD;
            end
        end

        // shift the window and advance the offset
        for (int i = 0; i < hevc_aub_pkg::WIN_DEPTH - 1; i++)
            held_bytes[i] = held_bytes[i + 1];
        held_bytes[hevc_aub_pkg::WIN_DEPTH - 1] = value;
        if (held_count < hevc_aub_pkg::WIN_DEPTH)
            held_count++;
        stream_pos++;

        // end record, then restart; the parameter-set flag carries over
        if (final_byte)
        begin
            queue_record(stream_pos, hevc_aub_pkg::KIND_END, 1'b0);
            held_bytes = '{default: 8'h00};
            stream_pos = '0;
            skip_count = '0;
            held_count = '0;
        end

        if (expected_records.size() > size_before)
            expected_records[expected_records.size() - 1].last = 1'b1;
    endtask

    task automatic check_record();
        aub_record_t want;
        if (expected_records.size() == 0)
        begin
            report_mismatch($sformatf("record at offset %0d kind %0b with none expected",
                                      out_mon.offset, out_mon.record_kind));
        end
        else
        begin
            want = expected_records.pop_front();
            if (out_mon.offset !== want.offset)
                report_mismatch($sformatf("offset %0d, expected %0d",
                                          out_mon.offset, want.offset));
            if (out_mon.record_kind !== want.kind)
                report_mismatch($sformatf("record_kind %0b, expected %0b at offset %0d",
                                          out_mon.record_kind, want.kind, want.offset));
            if (out_mon.starts_with_param_set !== want.param_set)
                report_mismatch($sformatf("starts_with_param_set %0b, expected %0b at offset %0d",
                                          out_mon.starts_with_param_set, want.param_set,
                                          want.offset));
            if (out_mon.last_of_run !== want.last)
                report_mismatch($sformatf("last_of_run %0b, expected %0b at offset %0d",
                                          out_mon.last_of_run, want.last, want.offset));
        end
    endtask

    // results are checked before the byte of the same edge is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_mon.valid && out_mon.ready)
                check_record();
            if (in_mon.valid && in_mon.ready)
                find_boundaries(in_mon.data_byte, in_mon.end_of_stream);
        end
        records_pending <= expected_records.size();
    end

endmodule

### tb/hevc_access_unit_boundary_finder_unit_tb.sv
`timescale 1ns / 1ps

module hevc_access_unit_boundary_finder_unit_tb;

    localparam int STREAM_BYTES = 1850;
    localparam int HOLD_AFTER   = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    // nal types used by the directed part and the top of the random type range
    localparam logic [5:0] NAL_TRAIL_R    = 6'd1;
    localparam logic [5:0] NAL_PREFIX_SEI = 6'd39;
    localparam logic [5:0] NAL_TYPE_MAX   = 6'd63;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } stream_byte_t;

    stream_byte_t stream_bytes[$];

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   records_pending;
    int   cycle_count = 0;

    hevc_aub_in_if  in_ch ();
    hevc_aub_out_if out_ch ();

    hevc_access_unit_boundary_finder_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    hevc_aub_boundary_monitor monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_mon          (in_ch),
        .out_mon         (out_ch),
        .mismatches      (mismatches),
        .records_pending (records_pending)
    );

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hevc_access_unit_boundary_finder_unit verification failed");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] value, input logic last);
        stream_byte_t sb;
        sb.value = value;
        sb.last  = last;
        stream_bytes.push_back(sb);
    endtask

    // start code, two header bytes and the first payload byte
    task automatic add_nal(input logic [5:0] unit_type, input logic [7:0] first_payload,
                           input logic long_code);
        if (long_code)
            add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte({1'($urandom_range(0, 1)), unit_type, 1'($urandom_range(0, 1))}, 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b0);
        add_byte(first_payload, 1'b0);
    endtask

    // payload with zero-heavy bytes so stray and overlapping start codes show up
    task automatic add_payload(input int len);
        int pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                add_byte(8'h00, 1'b0);
            else if (pick == 2)
                add_byte(8'h01, 1'b0);
            else
                add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic add_random_stream();
        int         nal_count;
        logic [5:0] unit_type;
        logic [7:0] first_payload;
        if ($urandom_range(0, 9) == 0)
        begin
            // noise, short streams included
            add_payload($urandom_range(1, 30));
        end
        else
        begin
            nal_count = $urandom_range(1, 6);
            for (int n = 0; n < nal_count; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                        unit_type = 6'($urandom_range(hevc_aub_pkg::FIRST_PS_TYPE,
                                                      hevc_aub_pkg::LAST_PS_TYPE));
                    3, 4, 5, 6, 7:
                        unit_type = 6'($urandom_range(0, hevc_aub_pkg::LAST_SLICE_TYPE));
                    8:
                        unit_type = 6'($urandom_range(hevc_aub_pkg::LAST_SLICE_TYPE + 1,
                                                      hevc_aub_pkg::FIRST_PS_TYPE - 1));
                    default:
                        unit_type = 6'($urandom_range(hevc_aub_pkg::LAST_PS_TYPE + 1,
                                                      NAL_TYPE_MAX));
                endcase
                first_payload = {($urandom_range(0, 3) != 0), 7'($urandom_range(0, 127))};
                add_nal(unit_type, first_payload, $urandom_range(0, 3) == 0);
                add_payload($urandom_range(0, 10));
            end
        end
        stream_bytes[stream_bytes.size() - 1].last = 1'b1;
    endtask

    // result side: stall patterns plus one long hold-off
    initial
    begin : result_sink
        int inputs_seen;
        int hold_left;
        int phase_left;
        int mode;
        bit hold_done;
        inputs_seen = 0;
        hold_left   = 0;
        phase_left  = 0;
        mode        = 0;
        hold_done   = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (in_ch.valid && in_ch.ready)
                inputs_seen++;
            if (!hold_done && inputs_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode       = $urandom_range(0, 3);
                    phase_left = $urandom_range(20, 120);
                end
                phase_left--;
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= (phase_left % 3 != 0);
                endcase
            end
        end
    end

    // byte side: reset, build the stream, drive it in bursts, then verdict
    initial
    begin : byte_source
        int burst_left;
        int gap;
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= 8'h00;
        in_ch.end_of_stream <= 1'b0;

        // one-byte stream
        add_byte(8'hFF, 1'b1);
        // vps opens a parameter-set run, a first slice ends it silently,
        // then a slice in the final window reports ahead of the end record
        add_nal(hevc_aub_pkg::FIRST_PS_TYPE, 8'h0C, 1'b0);
        add_nal(hevc_aub_pkg::LAST_SLICE_TYPE, 8'hAF, 1'b0);
        add_nal(NAL_TRAIL_R, 8'h80, 1'b0);
        stream_bytes[stream_bytes.size() - 1].last = 1'b1;
        // other nal type yields no boundary, only the end record
        add_nal(NAL_PREFIX_SEI, 8'h00, 1'b0);
        stream_bytes[stream_bytes.size() - 1].last = 1'b1;

        while (stream_bytes.size() < STREAM_BYTES)
            add_random_stream();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        burst_left = $urandom_range(1, 16);
        for (int i = 0; i < stream_bytes.size(); i++)
        begin
            in_ch.valid         <= 1'b1;
            in_ch.data_byte     <= stream_bytes[i].value;
            in_ch.end_of_stream <= stream_bytes[i].last;
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
            burst_left--;
            if (burst_left == 0)
            begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                          : $urandom_range(1, 16);
                if (gap > 0)
                begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        in_ch.valid <= 1'b0;
        @(posedge clk);

        // drain outstanding records
        while (records_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("hevc_access_unit_boundary_finder_unit verification clean");
        else
            $display("hevc_access_unit_boundary_finder_unit verification failed");
        $finish;
    end

endmodule
